[src/ascan_packet_deframer_unit_macros.svh]
// ----------------------------------------------------------------------------
// ascan packet deframer assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef ASCAN_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define ASCAN_PACKET_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication
`define APD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/apd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apd_pkg
// types, constants and helpers shared by the ascan packet deframer
// ----------------------------------------------------------------------------
package apd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int MAX_GATE     = 4096;
    localparam int MAX_SCANS    = 256;

    localparam int GATE_W = 13;
    localparam int SCAN_W = 9;
    localparam int POS_W  = 14;
    localparam int PKT_W  = 22;
    localparam int LEN_W  = 24;
    localparam int CFG_W  = 13;

    localparam logic [7:0] TYPE_SCAN = 8'd26;
    localparam logic [7:0] FMT_8BIT  = 8'd1;
    localparam logic [7:0] FMT_16BIT = 8'd4;

    // output queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // cycles the length registers need after a register write
    localparam logic [1:0] CFG_SETTLE = 2'd2;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2,
        KIND_STATUS = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_TYPE   = 2'd1,
        ERR_FORMAT = 2'd2,
        ERR_LENGTH = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        REG_SAMPLE_MODE = 2'd0,
        REG_GATE_LENGTH = 2'd1,
        REG_SCAN_COUNT  = 2'd2
    } reg_index_t;

    typedef struct packed {
        kind_t               kind;
        logic signed [15:0]  sample;
        logic                record_end;
        logic [7:0]          channel;
        logic [15:0]         test_number;
        err_t                error_code;
        logic [7:0]          sub_header;
        logic [SCAN_W-1:0]   records_received;
        logic                packet_valid;
        logic                last;
    } result_t;

    typedef struct packed {
        logic    first_valid;
        logic    second_valid;
        result_t first;
        result_t second;
    } push_t;

    function automatic logic [GATE_W-1:0] eff_gate(input logic [GATE_W-1:0] g);
        logic [GATE_W-1:0] r;
        r = g;
        if (g == '0)
            r = GATE_W'(1);
        else if (g > GATE_W'(MAX_GATE))
            r = GATE_W'(MAX_GATE);
        return r;
    endfunction

    function automatic logic [SCAN_W-1:0] eff_scans(input logic [SCAN_W-1:0] s);
        logic [SCAN_W-1:0] r;
        r = s;
        if (s == '0)
            r = SCAN_W'(1);
        else if (s > SCAN_W'(MAX_SCANS))
            r = SCAN_W'(MAX_SCANS);
        return r;
    endfunction

endpackage
`default_nettype wire

[src/apd_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apd_core
// record and packet state; turns one accepted byte into up to two results
// ----------------------------------------------------------------------------
`include "ascan_packet_deframer_unit_macros.svh"

module apd_core
    import apd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              wide,
    input  wire logic [POS_W-1:0]  rec_len,
    input  wire logic [PKT_W-1:0]  pkt_len,
    input  wire logic [SCAN_W-1:0] scans,
    output push_t                  push
);

    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [LEN_W-1:0]  len_reg,    len_next;
    logic [15:0]       test_reg,   test_next;
    logic [7:0]        format_reg, format_next;
    logic [7:0]        hold_reg,   hold_next;
    logic [SCAN_W-1:0] rc_reg,     rc_next;
    logic [PKT_W-1:0]  pbc_reg,    pbc_next;
    logic              disc_reg,   disc_next;

    logic              rec_last;
    logic              pkt_end;
    logic              err;
    logic              rec_valid;
    result_t           rec_res;
    result_t           stat_res;
    logic [7:0]        want_fmt;

    assign rec_last = ({1'b0, pos_reg} + (POS_W+1)'(1)) >= {1'b0, rec_len};
    assign pkt_end  = ({1'b0, pbc_reg} + (PKT_W+1)'(1)) >= {1'b0, pkt_len};
    assign want_fmt = wide ? FMT_16BIT : FMT_8BIT;

    always_comb
    begin
        pos_next    = pos_reg;
        len_next    = len_reg;
        test_next   = test_reg;
        format_next = format_reg;
        hold_next   = hold_reg;
        rc_next     = rc_reg;
        pbc_next    = pbc_reg;
        disc_next   = disc_reg;
        err         = 1'b0;
        rec_valid   = 1'b0;
        rec_res     = '0;
        stat_res    = '0;

        if (accept && !disc_reg)
        begin
            priority if (pos_reg == '0)
            begin
                len_next  = '0;
                test_next = '0;
                if (data_byte != TYPE_SCAN)
                begin
                    err                = 1'b1;
                    rec_valid          = 1'b1;
                    rec_res.kind       = KIND_ERROR;
                    rec_res.error_code = ERR_TYPE;
                    rec_res.sub_header = data_byte;
                end
            end
            else if (pos_reg == POS_W'(1))
                len_next = len_reg | {16'b0, data_byte};
            else if (pos_reg == POS_W'(2))
                len_next = len_reg | {8'b0, data_byte, 8'b0};
            else if (pos_reg == POS_W'(3))
                len_next = len_reg | {data_byte, 16'b0};
            else if (pos_reg == POS_W'(4))
                test_next = test_reg | {8'b0, data_byte};
            else if (pos_reg == POS_W'(5))
                test_next = test_reg | {data_byte, 8'b0};
            else if (pos_reg == POS_W'(6))
                format_next = data_byte;
            else if (pos_reg == POS_W'(HEADER_BYTES - 1))
            begin
                rec_valid = 1'b1;
                // format is checked ahead of length
                if (format_reg != want_fmt)
                begin
                    err                = 1'b1;
                    rec_res.kind       = KIND_ERROR;
                    rec_res.error_code = ERR_FORMAT;
                    rec_res.sub_header = TYPE_SCAN;
                end
                else if (len_reg != LEN_W'(rec_len))
                begin
                    err                = 1'b1;
                    rec_res.kind       = KIND_ERROR;
                    rec_res.error_code = ERR_LENGTH;
                    rec_res.sub_header = TYPE_SCAN;
                end
                else
                begin
                    if (rc_reg < SCAN_W'(MAX_SCANS))
                        rc_next = rc_reg + SCAN_W'(1);
                    rec_res.kind        = KIND_HEADER;
                    rec_res.channel     = data_byte;
                    rec_res.test_number = test_reg;
                end
            end
            else
            begin
                if (!wide)
                begin
                    rec_valid          = 1'b1;
                    rec_res.kind       = KIND_SAMPLE;
                    rec_res.sample     = {8'b0, data_byte};
                    rec_res.record_end = rec_last;
                end
                else if (!pos_reg[0])
                    hold_next = data_byte;
                else
                begin
                    rec_valid          = 1'b1;
                    rec_res.kind       = KIND_SAMPLE;
                    rec_res.sample     = {data_byte, hold_reg};
                    rec_res.record_end = rec_last;
                end
            end

            if (err)
            begin
                disc_next = 1'b1;
                pos_next  = '0;
            end
            else
                pos_next = rec_last ? '0 : pos_reg + POS_W'(1);
        end

        if (accept)
        begin
            if (pkt_end)
            begin
                stat_res.kind             = KIND_STATUS;
                stat_res.records_received = rc_next;
                stat_res.packet_valid     = (rc_next == scans);
                stat_res.last             = 1'b1;
                pbc_next  = '0;
                pos_next  = '0;
                rc_next   = '0;
                disc_next = 1'b0;
            end
            else
                pbc_next = pbc_reg + PKT_W'(1);
        end

        rec_res.last = !pkt_end;

        push.first_valid  = accept && (rec_valid || pkt_end);
        push.second_valid = accept && rec_valid && pkt_end;
        push.first        = rec_valid ? rec_res : stat_res;
        push.second       = stat_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            len_reg    <= '0;
            test_reg   <= '0;
            format_reg <= '0;
            hold_reg   <= '0;
            rc_reg     <= '0;
            pbc_reg    <= '0;
            disc_reg   <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            test_reg   <= test_next;
            format_reg <= format_next;
            hold_reg   <= hold_next;
            rc_reg     <= rc_next;
            pbc_reg    <= pbc_next;
            disc_reg   <= disc_next;
        end
    end

    `APD_ASSERT_IMPLY(a_second_is_status, push.second_valid, push.first_valid && push.second.kind == KIND_STATUS, "second request is not a status")
    `APD_ASSERT_IMPLY(a_discard_silent, disc_reg && push.first_valid, push.first.kind == KIND_STATUS && !push.second_valid, "record result while discarding")
    `APD_ASSERT_IMPLY(a_rc_bound, 1'b1, rc_reg <= SCAN_W'(MAX_SCANS), "record count above limit")
    `APD_ASSERT_NEXT(a_error_discards, accept && push.first_valid && push.first.kind == KIND_ERROR && !pkt_end, disc_reg && pos_reg == '0, "error did not start discard")

endmodule
`default_nettype wire

[src/apd_out_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apd_out_queue
// small result queue: takes up to two results a cycle; while out_stall is low, gives one
// ----------------------------------------------------------------------------
`include "ascan_packet_deframer_unit_macros.svh"

module apd_out_queue
    import apd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  push_t     push,
    output logic      almost_full,
    output logic      out_valid,
    input  wire logic out_stall,
    output result_t   head
);

    result_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]    count_reg,  count_next;
    logic                  pop;
    logic [Q_PTR_W-1:0]    wr_ptr_2nd;

    assign out_valid   = (count_reg != '0);
    assign head        = entry_reg[rd_ptr_reg];
    assign pop         = out_valid && !out_stall;
    // room must remain for a byte that makes two results
    assign almost_full = (count_reg > Q_CNT_W'(Q_DEPTH - 2));
    assign wr_ptr_2nd  = wr_ptr_reg + Q_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + Q_PTR_W'(push.first_valid) + Q_PTR_W'(push.second_valid);
        rd_ptr_next = rd_ptr_reg + Q_PTR_W'(pop);
        count_next  = count_reg + Q_CNT_W'(push.first_valid) + Q_CNT_W'(push.second_valid)
                      - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first_valid)
            entry_reg[wr_ptr_reg] <= push.first;
        if (push.second_valid)
            entry_reg[wr_ptr_2nd] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `APD_ASSERT_IMPLY(a_q_bound, 1'b1, count_reg <= Q_CNT_W'(Q_DEPTH), "queue count above depth")
    `APD_ASSERT_IMPLY(a_q_room, push.first_valid, count_reg <= Q_CNT_W'(Q_DEPTH - 2), "request pushed without room")

endmodule
`default_nettype wire

[src/ascan_packet_deframer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascan_packet_deframer_unit
// splits an ultrasonic a-scan packet byte stream into headers, samples,
// error reports and a packet status
// ----------------------------------------------------------------------------
// usage
//   data channel: one raw packet byte per request on data_byte, valid/stall.
//   result channel: one result per request, valid/stall; kind tells which
//   fields carry meaning, last marks the final result of a byte.
//   results of an accepted byte are registered into the result queue and
//   offered from its head. one byte per cycle while data_stall is low; a
//   packet-end byte that also makes a record result gives two results, which a
//   four-entry result queue absorbs; data_stall rises while it holds three
//   or more. register writes (cfg_write, cfg_index, cfg_data) must be made
//   while idle, which the block itself does not enforce; data_stall is held
//   until the record, then packet, length registers follow, also after reset.
//   reset: all counters clear, the queue empties, registers return to
//   8-bit mode, gate length 1, one scan per packet.
//   a stalled receiver backs up the queue and then the data channel; no
//   result is lost.
// ----------------------------------------------------------------------------

module ascan_packet_deframer_unit
    import apd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,
    input  wire logic               data_valid,
    output logic                    data_stall,
    input  wire logic [7:0]         data_byte,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic [1:0]              kind,
    output logic signed [15:0]      sample,
    output logic                    record_end,
    output logic [7:0]              channel,
    output logic [15:0]             test_number,
    output logic [1:0]              error_code,
    output logic [7:0]              sub_header,
    output logic [SCAN_W-1:0]       records_received,
    output logic                    packet_valid,
    output logic                    last
);

    logic                   mode_reg;
    logic [GATE_W-1:0]      gate_reg;
    logic [SCAN_W-1:0]      scan_reg;
    logic [1:0]             settle_reg, settle_next;
    logic [POS_W-1:0]       rec_len_reg, rec_len_next;
    logic [PKT_W-1:0]       pkt_len_reg, pkt_len_next;
    logic [GATE_W-1:0]      gate_eff;
    logic [SCAN_W-1:0]      scans_eff;
    logic [SCAN_W+POS_W-1:0] pkt_prod;
    logic                   almost_full;
    logic                   accept;
    push_t                  push;
    result_t                head;

    assign gate_eff  = eff_gate(gate_reg);
    assign scans_eff = eff_scans(scan_reg);

    always_comb
    begin
        rec_len_next = POS_W'(HEADER_BYTES)
                       + (mode_reg ? {gate_eff, 1'b0} : {1'b0, gate_eff});
        pkt_prod     = scans_eff * rec_len_reg;
        pkt_len_next = pkt_prod[PKT_W-1:0];
        settle_next  = settle_reg;
        if (cfg_write)
            settle_next = CFG_SETTLE;
        else if (settle_reg != '0)
            settle_next = settle_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            gate_reg   <= GATE_W'(1);
            scan_reg   <= SCAN_W'(1);
            settle_reg <= CFG_SETTLE;
        end
        else
        begin
            settle_reg <= settle_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_SAMPLE_MODE: mode_reg <= cfg_data[0];
                    REG_GATE_LENGTH: gate_reg <= cfg_data[GATE_W-1:0];
                    REG_SCAN_COUNT:  scan_reg <= cfg_data[SCAN_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // derived lengths: record length registered from the configuration, packet length from it
    always_ff @(posedge clk)
    begin
        rec_len_reg <= rec_len_next;
        pkt_len_reg <= pkt_len_next;
    end

    assign data_stall = almost_full || (settle_reg != '0);
    assign accept     = data_valid && !data_stall;

    apd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .wide      (mode_reg),
        .rec_len   (rec_len_reg),
        .pkt_len   (pkt_len_reg),
        .scans     (scans_eff),
        .push      (push)
    );

    apd_out_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .almost_full (almost_full),
        .out_valid   (result_valid),
        .out_stall   (result_stall),
        .head        (head)
    );

    assign kind             = head.kind;
    assign sample           = head.sample;
    assign record_end       = head.record_end;
    assign channel          = head.channel;
    assign test_number      = head.test_number;
    assign error_code       = head.error_code;
    assign sub_header       = head.sub_header;
    assign records_received = head.records_received;
    assign packet_valid     = head.packet_valid;
    assign last             = head.last;

endmodule
`default_nettype wire

[tb/sv/ascan_packet_deframer_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascan_packet_deframer_unit_test
// feeds a-scan packet byte streams (clean records, broken sub-headers, noise
// and register changes part way through a packet) into the deframer, tracks
// the expected headers, samples, error reports and packet status with its own
// deframing model and compares every result field by field
// ----------------------------------------------------------------------------

module ascan_packet_deframer_unit_test
    import apd_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 4;

    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_TYPE,
        FLAW_FORMAT,
        FLAW_LENGTH,
        FLAW_BOTH
    } flaw_t;

    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               cfg_write    = 1'b0;
    logic [1:0]         cfg_index    = '0;
    logic [CFG_W-1:0]   cfg_data     = '0;
    logic               data_valid   = 1'b0;
    logic               data_stall;
    logic [7:0]         data_byte    = '0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic               record_end;
    logic [7:0]         channel;
    logic [15:0]        test_number;
    logic [1:0]         error_code;
    logic [7:0]         sub_header;
    logic [SCAN_W-1:0]  records_received;
    logic               packet_valid;
    logic               last;

    ascan_packet_deframer_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .data_valid       (data_valid),
        .data_stall       (data_stall),
        .data_byte        (data_byte),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .kind             (kind),
        .sample           (sample),
        .record_end       (record_end),
        .channel          (channel),
        .test_number      (test_number),
        .error_code       (error_code),
        .sub_header       (sub_header),
        .records_received (records_received),
        .packet_valid     (packet_valid),
        .last             (last)
    );

    always #1 clk = ~clk;

    // register copies
    logic               cfg_mode  = 1'b0;
    logic [GATE_W-1:0]  cfg_gate  = GATE_W'(1);
    logic [SCAN_W-1:0]  cfg_scans = SCAN_W'(1);

    // deframing state
    int unsigned rec_pos   = 0;
    int unsigned len_acc   = 0;
    int unsigned test_acc  = 0;
    logic [7:0]  fmt_seen  = '0;
    logic [7:0]  low_hold  = '0;
    int unsigned rec_count = 0;
    int unsigned pkt_pos   = 0;
    bit          dropping  = 1'b0;

    result_t     expected_results[$];
    logic [7:0]  packet_stream[$];
    logic [7:0]  sample_pattern[$];
    result_t     want;
    int unsigned live_bytes    = 0;
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_request  = 1'b0;
    int unsigned hold_left     = 0;

    function automatic int unsigned record_bytes();
        int unsigned g;
        g = cfg_gate;
        if (g == 0)
            g = 1;
        else if (g > MAX_GATE)
            g = MAX_GATE;
        return HEADER_BYTES + (cfg_mode ? 2 : 1) * g;
    endfunction

    function automatic int unsigned scans_per_packet();
        int unsigned s;
        s = cfg_scans;
        if (s == 0)
            s = 1;
        else if (s > MAX_SCANS)
            s = MAX_SCANS;
        return s;
    endfunction

    // expected results of one accepted packet byte
    function automatic void deframe_byte(input logic [7:0] b);
        result_t     found[2];
        int          n;
        int unsigned rlen, plen, scans, pos, off;
        bit          bad, rec_last;
        rlen = record_bytes();
        scans = scans_per_packet();
        plen = scans * rlen;
        n = 0;
        found[0] = '0;
        found[1] = '0;
        if (!dropping)
        begin
            live_bytes++;
            pos = rec_pos;
            bad = 1'b0;
            rec_last = (pos + 1 >= rlen);
            if (pos == 0)
            begin
                len_acc = 0;
                test_acc = 0;
                if (b != TYPE_SCAN)
                begin
                    found[n].kind = KIND_ERROR;
                    found[n].error_code = ERR_TYPE;
                    found[n].sub_header = b;
                    n++;
                    bad = 1'b1;
                end
            end
            else if (pos <= 3)
                len_acc = (len_acc | (32'(b) << (8 * (pos - 1)))) & 32'hFF_FFFF;
            else if (pos <= 5)
                test_acc = (test_acc | (32'(b) << (8 * (pos - 4)))) & 32'hFFFF;
            else if (pos == 6)
                fmt_seen = b;
            else if (pos == HEADER_BYTES - 1)
            begin
                // format is checked ahead of length
                if (fmt_seen != (cfg_mode ? FMT_16BIT : FMT_8BIT))
                begin
                    found[n].kind = KIND_ERROR;
                    found[n].error_code = ERR_FORMAT;
                    found[n].sub_header = TYPE_SCAN;
                    n++;
                    bad = 1'b1;
                end
                else if (len_acc != rlen)
                begin
                    found[n].kind = KIND_ERROR;
                    found[n].error_code = ERR_LENGTH;
                    found[n].sub_header = TYPE_SCAN;
                    n++;
                    bad = 1'b1;
                end
                else
                begin
                    if (rec_count < MAX_SCANS)
                        rec_count++;
                    found[n].kind = KIND_HEADER;
                    found[n].channel = b;
                    found[n].test_number = test_acc[15:0];
                    n++;
                end
            end
            else
            begin
                off = pos - HEADER_BYTES;
                if (!cfg_mode)
                begin
                    found[n].kind = KIND_SAMPLE;
                    found[n].sample = {8'h00, b};
                    found[n].record_end = rec_last;
                    n++;
                end
                else if (off[0] == 1'b0)
                    low_hold = b;
                else
                begin
                    found[n].kind = KIND_SAMPLE;
                    found[n].sample = {b, low_hold};
                    found[n].record_end = rec_last;
                    n++;
                end
            end
            if (bad)
            begin
                dropping = 1'b1;
                rec_pos = 0;
            end
            else
                rec_pos = rec_last ? 0 : pos + 1;
        end
        if (pkt_pos + 1 >= plen)
        begin
            found[n].kind = KIND_STATUS;
            found[n].records_received = SCAN_W'(rec_count);
            found[n].packet_valid = (rec_count == scans);
            n++;
            pkt_pos = 0;
            rec_pos = 0;
            rec_count = 0;
            dropping = 1'b0;
        end
        else
            pkt_pos++;
        for (int i = 0; i < n; i++)
        begin
            if (i == n - 1)
                found[i].last = 1'b1;
            expected_results.insert(expected_results.size(), found[i]);
        end
    endfunction

    // appends one record to the byte stream, optionally with a broken sub-header
    function automatic void build_record(input flaw_t flaw, input logic [15:0] test_no,
                                         input logic [7:0] chan);
        logic [7:0]  type_byte, fmt;
        logic [23:0] len_field;
        int unsigned rlen;
        rlen = record_bytes();
        type_byte = TYPE_SCAN;
        fmt = cfg_mode ? FMT_16BIT : FMT_8BIT;
        len_field = 24'(rlen);
        if (flaw == FLAW_TYPE)
        begin
            do
                type_byte = 8'($urandom_range(0, 255));
            while (type_byte == TYPE_SCAN);
        end
        if (flaw == FLAW_FORMAT || flaw == FLAW_BOTH)
        begin
            if ($urandom_range(0, 1) == 0)
                fmt = cfg_mode ? FMT_8BIT : FMT_16BIT;
            else
            begin
                do
                    fmt = 8'($urandom_range(0, 255));
                while (fmt == (cfg_mode ? FMT_16BIT : FMT_8BIT));
            end
        end
        if (flaw == FLAW_LENGTH || flaw == FLAW_BOTH)
            len_field = len_field ^ (24'd1 << $urandom_range(0, 23));
        packet_stream.insert(packet_stream.size(), type_byte);
        packet_stream.insert(packet_stream.size(), len_field[7:0]);
        packet_stream.insert(packet_stream.size(), len_field[15:8]);
        packet_stream.insert(packet_stream.size(), len_field[23:16]);
        packet_stream.insert(packet_stream.size(), test_no[7:0]);
        packet_stream.insert(packet_stream.size(), test_no[15:8]);
        packet_stream.insert(packet_stream.size(), fmt);
        packet_stream.insert(packet_stream.size(), chan);
        for (int unsigned i = HEADER_BYTES; i < rlen; i++)
        begin
            if (sample_pattern.size() != 0)
                packet_stream.insert(packet_stream.size(),
                    sample_pattern[(i - HEADER_BYTES) % sample_pattern.size()]);
            else
                packet_stream.insert(packet_stream.size(), 8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void build_packet(input flaw_t flaw, input int flaw_rec);
        for (int r = 0; r < int'(scans_per_packet()); r++)
            build_record((r == flaw_rec) ? flaw : FLAW_NONE, 16'($urandom), 8'($urandom));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        deframe_byte(b);
    endtask

    task automatic send_stream(input int unsigned count);
        repeat (count)
            send_byte(packet_stream.pop_front());
    endtask

    // runs the packet counter back to a packet boundary
    task automatic finish_packet();
        while (pkt_pos != 0)
            send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic await_results();
        data_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic load_config(input logic mode, input logic [CFG_W-1:0] gate,
                               input logic [CFG_W-1:0] scans);
        await_results();
        cfg_write <= 1'b1;
        cfg_index <= REG_SAMPLE_MODE;
        cfg_data <= CFG_W'(mode);
        @(posedge clk);
        cfg_index <= REG_GATE_LENGTH;
        cfg_data <= gate;
        @(posedge clk);
        cfg_index <= REG_SCAN_COUNT;
        cfg_data <= scans;
        @(posedge clk);
        cfg_write <= 1'b0;
        cfg_mode = mode;
        cfg_gate = gate;
        cfg_scans = scans[SCAN_W-1:0];
    endtask

    task automatic random_config();
        load_config(1'($urandom_range(0, 1)),
                    ($urandom_range(0, 9) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(1, 6)),
                    ($urandom_range(0, 9) == 0) ? CFG_W'(0) : CFG_W'($urandom_range(1, 4)));
    endtask

    task automatic test_record_fields();
        load_config(1'b0, CFG_W'(1), CFG_W'(2));
        sample_pattern.delete();
        sample_pattern.insert(sample_pattern.size(), 8'h00);
        build_record(FLAW_NONE, 16'h0000, 8'h00);
        sample_pattern.delete();
        sample_pattern.insert(sample_pattern.size(), 8'hFF);
        // last sample of the packet also carries the status
        build_record(FLAW_NONE, 16'hFFFF, 8'hFF);
        sample_pattern.delete();
        send_stream(packet_stream.size());
    endtask

    task automatic test_wide_samples();
        load_config(1'b1, CFG_W'(2), CFG_W'(1));
        sample_pattern.delete();
        sample_pattern.insert(sample_pattern.size(), 8'h00);
        sample_pattern.insert(sample_pattern.size(), 8'h80);
        sample_pattern.insert(sample_pattern.size(), 8'hFF);
        sample_pattern.insert(sample_pattern.size(), 8'h7F);
        build_record(FLAW_NONE, 16'h1234, 8'h5A);
        sample_pattern.delete();
        send_stream(packet_stream.size());
    endtask

    task automatic test_header_errors();
        load_config(1'b0, CFG_W'(1), CFG_W'(1));
        build_packet(FLAW_TYPE, 0);
        build_packet(FLAW_FORMAT, 0);
        build_packet(FLAW_LENGTH, 0);
        build_packet(FLAW_BOTH, 0);
        send_stream(packet_stream.size());
    endtask

    task automatic test_mid_packet_config();
        load_config(1'b1, CFG_W'(4), CFG_W'(1));
        build_packet(FLAW_NONE, -1);
        // header and one full word, then shrink the record under it
        send_stream(HEADER_BYTES + 2);
        packet_stream.delete();
        load_config(1'b1, CFG_W'(1), CFG_W'(1));
        finish_packet();
    endtask

    task automatic run_random_traffic(input int unsigned count);
        int unsigned stop, pick, cut;
        stop = live_bytes + count;
        while (live_bytes < stop)
        begin
            if ($urandom_range(0, 3) == 0)
                random_config();
            pick = $urandom_range(0, 99);
            if (pick < 70)
                build_packet(FLAW_NONE, -1);
            else if (pick < 85)
                build_packet(flaw_t'($urandom_range(1, 4)),
                             $urandom_range(0, scans_per_packet() - 1));
            else if (pick < 93)
            begin
                repeat ($urandom_range(1, 12))
                    packet_stream.insert(packet_stream.size(), 8'($urandom_range(0, 255)));
            end
            else
            begin
                build_packet(FLAW_NONE, -1);
                cut = $urandom_range(1, packet_stream.size() - 1);
                send_stream(cut);
                packet_stream.delete();
                random_config();
            end
            send_stream(packet_stream.size());
            finish_packet();
        end
    endtask

    task automatic test_backpressure();
        int unsigned saved_idle;
        load_config(1'b0, CFG_W'(8), CFG_W'(4));
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        hold_request = 1'b1;
        build_packet(FLAW_NONE, -1);
        send_stream(packet_stream.size());
        // sender waits here for the backlog to drain
        await_results();
        send_idle_pct = saved_idle;
    endtask

    // sends the head of a long packet, then shrinks the packet to end it
    task automatic send_packet_head(input int unsigned count, input logic mode);
        build_packet(FLAW_NONE, -1);
        send_stream(count);
        packet_stream.delete();
        load_config(mode, CFG_W'(1), CFG_W'(1));
        finish_packet();
    endtask

    task automatic test_config_extremes();
        load_config(1'b0, CFG_W'(0), CFG_W'(0));
        build_packet(FLAW_NONE, -1);
        send_stream(packet_stream.size());
        // header length field is built from the clamped gate length
        load_config(1'b0, CFG_W'(8191), CFG_W'(1));
        send_packet_head(HEADER_BYTES + 4, 1'b0);
        load_config(1'b1, CFG_W'(MAX_GATE), CFG_W'(1));
        send_packet_head(HEADER_BYTES + 4, 1'b1);
        load_config(1'b0, CFG_W'(1), CFG_W'(MAX_SCANS));
        send_packet_head(4 * (HEADER_BYTES + 1), 1'b0);
        load_config(1'b1, CFG_W'(0), CFG_W'(511));
        send_packet_head(3 * (HEADER_BYTES + 2), 1'b1);
    endtask

    // receiver: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic int unsigned field_mismatch(input string name, input logic [31:0] exp_v,
                                                   input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, kind %0d", $time, kind);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                error_count += field_mismatch("kind", want.kind, kind);
                error_count += field_mismatch("sample", want.sample, sample);
                error_count += field_mismatch("record_end", want.record_end, record_end);
                error_count += field_mismatch("channel", want.channel, channel);
                error_count += field_mismatch("test_number", want.test_number, test_number);
                error_count += field_mismatch("error_code", want.error_code, error_code);
                error_count += field_mismatch("sub_header", want.sub_header, sub_header);
                error_count += field_mismatch("records_received", want.records_received,
                                              records_received);
                error_count += field_mismatch("packet_valid", want.packet_valid, packet_valid);
                error_count += field_mismatch("last", want.last, last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ascan_packet_deframer_unit_test: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 69;
        test_record_fields();
        test_wide_samples();
        test_header_errors();
        test_mid_packet_config();
        run_random_traffic(80);

        send_idle_pct = 69;
        recv_idle_pct = 17;
        run_random_traffic(80);
        test_backpressure();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_traffic(80);
        test_config_extremes();

        await_results();
        repeat (20)
            @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("ascan_packet_deframer_unit_test: clean");
        else
            $display("ascan_packet_deframer_unit_test: errors");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/apd_pkg.sv
src/apd_core.sv
src/apd_out_queue.sv
src/ascan_packet_deframer_unit.sv
tb/sv/ascan_packet_deframer_unit_test.sv
